@@ hw/rtl/qie_pkg.sv @@
// ----------------------------------------------------------------------------
// QOI image encoder package
// Shared payload types, opcodes, header constants and the color hash.
// ----------------------------------------------------------------------------
package qie_pkg;

   // request commands
   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_PIXEL  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   // register indexes
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 1'd1;

   // opcodes
   localparam logic [7:0] OP_INDEX = 8'h00;
   localparam logic [7:0] OP_DIFF  = 8'h40;
   localparam logic [7:0] OP_LUMA  = 8'h80;
   localparam logic [7:0] OP_RUN   = 8'hc0;
   localparam logic [7:0] OP_RGB   = 8'hfe;
   localparam logic [7:0] OP_RGBA  = 8'hff;
   localparam logic [5:0] RUN_MAX  = 6'd62;

   // header and end marker
   localparam logic [31:0] HDR_MAGIC      = 32'h716f6966; // "qoif"
   localparam logic [7:0]  HDR_CHANNELS   = 8'd4;
   localparam logic [7:0]  HDR_COLORSPACE = 8'd0;
   localparam logic [3:0]  HDR_LEN        = 4'd14;
   localparam logic [3:0]  END_LEN        = 4'd8;
   localparam logic [7:0]  END_LAST       = 8'h01;

   localparam int unsigned INDEX_DEPTH = 64;
   localparam int unsigned HASH_W      = 6;
   localparam int unsigned CODE_MAX    = 5;
   localparam int unsigned QDEPTH      = 4;
   localparam int unsigned QPTR_W      = 2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } pix_type;

   typedef enum logic [1:0] {
      KIND_PIX = 2'd0,
      KIND_HDR = 2'd1,
      KIND_FIN = 2'd2
   } kind_type;

   // work item handed from the classifier to the byte emitter
   typedef struct packed {
      kind_type                   kind;
      logic                       has_run;
      logic [7:0]                 run_byte;
      logic [2:0]                 code_len;
      logic [CODE_MAX-1:0][7:0]   code;
   } desc_type;

   function automatic logic [HASH_W-1:0] hash_of(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [7:0] a);
      logic [11:0] s;
      s = 12'(r) * 12'd3 + 12'(g) * 12'd5 + 12'(b) * 12'd7 + 12'(a) * 12'd11;
      return s[HASH_W-1:0];
   endfunction

endpackage

@@ hw/rtl/qie_front.sv @@
// ----------------------------------------------------------------------------
// QOI encoder front end
// Accepts requests, looks up the color index and picks the code for each pixel.
// ----------------------------------------------------------------------------
module qie_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  qie_pkg::req_type    req_data,
   output logic                q_push,
   output qie_pkg::desc_type   q_data,
   input  logic                q_full
);
   import qie_pkg::*;

   logic                    accept;
   logic                    s1_go;
   logic [HASH_W-1:0]       hash_in;

   logic                    s1_valid_ff;
   req_type                 s1_req_ff;
   logic [HASH_W-1:0]       s1_hash_ff;
   pix_type                 rd_data_ff;
   logic                    rd_vld_ff;
   logic                    byp_hit_ff;
   pix_type                 byp_data_ff;
   logic                    clr_ff;

   pix_type                 prev_ff, prev_in;
   logic [5:0]              run_ff, run_in;
   logic [INDEX_DEPTH-1:0]  vld_ff;
   pix_type                 mem [INDEX_DEPTH];

   pix_type                 px;
   pix_type                 entry;
   logic                    wr_need, clr_need, push_need;
   logic                    wr_en, clr_en;
   desc_type                d;
   logic [5:0]              run_p1;
   logic signed [8:0]       vr, vg, vb;
   logic signed [9:0]       rg, bg;
   logic                    is_diff, is_luma;
   logic [1:0]              dr2, dg2, db2;
   logic [5:0]              vg6;
   logic [3:0]              rg4, bg4;

   assign hash_in  = hash_of(req_data.red, req_data.green, req_data.blue, req_data.alpha);
   assign s1_go    = s1_valid_ff && !q_full;
   assign req_full = s1_valid_ff && q_full;
   assign accept   = req_push && !req_full;

   assign px = '{r: s1_req_ff.red, g: s1_req_ff.green, b: s1_req_ff.blue, a: s1_req_ff.alpha};

   // index entry as seen by this pixel, including a write or clear in the same edge
   always_comb begin
      if (byp_hit_ff) begin
         entry = byp_data_ff;
      end else if (clr_ff || !rd_vld_ff) begin
         entry = '0;
      end else begin
         entry = rd_data_ff;
      end
   end

   always_comb begin
      vr = $signed({1'b0, px.r}) - $signed({1'b0, prev_ff.r});
      vg = $signed({1'b0, px.g}) - $signed({1'b0, prev_ff.g});
      vb = $signed({1'b0, px.b}) - $signed({1'b0, prev_ff.b});
      rg = $signed({vr[8], vr}) - $signed({vg[8], vg});
      bg = $signed({vb[8], vb}) - $signed({vg[8], vg});
      is_diff = (vr >= -9'sd2) && (vr <= 9'sd1) && (vg >= -9'sd2) && (vg <= 9'sd1) &&
                (vb >= -9'sd2) && (vb <= 9'sd1);
      is_luma = (rg >= -10'sd8) && (rg <= 10'sd7) && (vg >= -9'sd32) && (vg <= 9'sd31) &&
                (bg >= -10'sd8) && (bg <= 10'sd7);
      dr2 = vr[1:0] + 2'd2;
      dg2 = vg[1:0] + 2'd2;
      db2 = vb[1:0] + 2'd2;
      vg6 = vg[5:0] + 6'd32;
      rg4 = rg[3:0] + 4'd8;
      bg4 = bg[3:0] + 4'd8;
   end

   always_comb begin
      d         = '0;
      d.kind    = KIND_PIX;
      d.has_run = (run_ff != 6'd0);
      d.run_byte = OP_RUN | {2'b00, run_ff - 6'd1};
      prev_in   = prev_ff;
      run_in    = run_ff;
      wr_need   = 1'b0;
      clr_need  = 1'b0;
      push_need = 1'b0;
      run_p1    = run_ff + 6'd1;
      unique case (s1_req_ff.cmd)
         CMD_BEGIN: begin
            d.kind    = KIND_HDR;
            d.has_run = 1'b0;
            push_need = 1'b1;
            prev_in   = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
            run_in    = 6'd0;
            clr_need  = 1'b1;
         end
         CMD_PIXEL: begin
            if (px == prev_ff) begin
               if (run_p1 == RUN_MAX) begin
                  d.has_run  = 1'b1;
                  d.run_byte = OP_RUN | {2'b00, run_ff};
                  push_need  = 1'b1;
                  run_in     = 6'd0;
               end else begin
                  run_in = run_p1;
               end
            end else begin
               push_need = 1'b1;
               run_in    = 6'd0;
               prev_in   = px;
               if (entry == px) begin
                  d.code_len = 3'd1;
                  d.code[0]  = OP_INDEX | {2'b00, s1_hash_ff};
               end else begin
                  wr_need = 1'b1;
                  if (px.a != prev_ff.a) begin
                     d.code_len = 3'd5;
                     d.code     = {px.a, px.b, px.g, px.r, OP_RGBA};
                  end else if (is_diff) begin
                     d.code_len = 3'd1;
                     d.code[0]  = OP_DIFF | {2'b00, dr2, dg2, db2};
                  end else if (is_luma) begin
                     d.code_len = 3'd2;
                     d.code[0]  = OP_LUMA | {2'b00, vg6};
                     d.code[1]  = {rg4, bg4};
                  end else begin
                     d.code_len = 3'd4;
                     d.code[0]  = OP_RGB;
                     d.code[1]  = px.r;
                     d.code[2]  = px.g;
                     d.code[3]  = px.b;
                  end
               end
            end
         end
         CMD_FINISH: begin
            d.kind    = KIND_FIN;
            push_need = 1'b1;
            run_in    = 6'd0;
         end
         default: begin
         end
      endcase
   end

   assign wr_en  = s1_go && wr_need;
   assign clr_en = s1_go && clr_need;
   assign q_push = s1_go && push_need;
   assign q_data = d;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prev_ff     <= '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
         run_ff      <= 6'd0;
         vld_ff      <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go) begin
            prev_ff <= prev_in;
            run_ff  <= run_in;
         end
         if (clr_en) begin
            vld_ff <= '0;
         end else if (wr_en) begin
            vld_ff[s1_hash_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req_data;
         s1_hash_ff  <= hash_in;
         rd_vld_ff   <= vld_ff[hash_in];
         byp_hit_ff  <= wr_en && (s1_hash_ff == hash_in);
         byp_data_ff <= px;
         clr_ff      <= clr_en;
      end
   end

   // color index memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_hash_ff] <= px;
      end
      if (accept) begin
         rd_data_ff <= mem[hash_in];
      end
   end

endmodule

@@ hw/rtl/qie_queue.sv @@
// ----------------------------------------------------------------------------
// QOI encoder work queue
// Short FIFO of classified items between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module qie_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qie_pkg::desc_type   push_data,
   output logic                full,
   input  logic                pop,
   output qie_pkg::desc_type   pop_data,
   output logic                empty
);
   import qie_pkg::*;

   desc_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;
   logic               do_push, do_pop;

   assign full     = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/qie_back.sv @@
// ----------------------------------------------------------------------------
// QOI encoder byte emitter
// Walks each queued item out one byte per cycle while the output is popped.
// ----------------------------------------------------------------------------
module qie_back (
   input  logic                clock,
   input  logic                reset,
   input  qie_pkg::desc_type   q_data,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic [31:0]         image_width,
   input  logic [31:0]         image_height,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output qie_pkg::rsp_type    rsp_data
);
   import qie_pkg::*;

   logic [3:0]   pos_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;
   logic [3:0]   run_n;
   logic [3:0]   total;
   logic [3:0]   j;
   logic         last;
   logic         load;
   logic         in_run;
   logic [7:0]   byte_sel;
   logic [7:0]   hdr_byte;
   logic [7:0]   code_byte;

   assign run_n  = {3'b000, q_data.has_run};
   assign j      = pos_ff - run_n;
   assign in_run = q_data.has_run && (pos_ff == 4'd0);

   always_comb begin
      unique case (q_data.kind)
         KIND_PIX: total = run_n + {1'b0, q_data.code_len};
         KIND_HDR: total = HDR_LEN;
         KIND_FIN: total = run_n + END_LEN;
         default:  total = 4'd1;
      endcase
   end

   assign last = (pos_ff == total - 4'd1);

   always_comb begin
      unique case (pos_ff)
         4'd0:    hdr_byte = HDR_MAGIC[31:24];
         4'd1:    hdr_byte = HDR_MAGIC[23:16];
         4'd2:    hdr_byte = HDR_MAGIC[15:8];
         4'd3:    hdr_byte = HDR_MAGIC[7:0];
         4'd4:    hdr_byte = image_width[31:24];
         4'd5:    hdr_byte = image_width[23:16];
         4'd6:    hdr_byte = image_width[15:8];
         4'd7:    hdr_byte = image_width[7:0];
         4'd8:    hdr_byte = image_height[31:24];
         4'd9:    hdr_byte = image_height[23:16];
         4'd10:   hdr_byte = image_height[15:8];
         4'd11:   hdr_byte = image_height[7:0];
         4'd12:   hdr_byte = HDR_CHANNELS;
         4'd13:   hdr_byte = HDR_COLORSPACE;
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      unique case (j)
         4'd0:    code_byte = q_data.code[0];
         4'd1:    code_byte = q_data.code[1];
         4'd2:    code_byte = q_data.code[2];
         4'd3:    code_byte = q_data.code[3];
         4'd4:    code_byte = q_data.code[4];
         default: code_byte = 8'h00;
      endcase
   end

   always_comb begin
      unique case (q_data.kind)
         KIND_HDR: byte_sel = hdr_byte;
         KIND_PIX: byte_sel = in_run ? q_data.run_byte : code_byte;
         KIND_FIN: begin
            if (in_run) begin
               byte_sel = q_data.run_byte;
            end else begin
               byte_sel = (j == END_LEN - 4'd1) ? END_LAST : 8'h00;
            end
         end
         default:  byte_sel = 8'h00;
      endcase
   end

   assign load      = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop     = load && last;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            pos_ff       <= last ? 4'd0 : pos_ff + 4'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.out_byte  <= byte_sel;
         rsp_ff.last_byte <= last;
      end
   end

endmodule

@@ hw/rtl/qoi_image_encoder_top.sv @@
// ----------------------------------------------------------------------------
// QOI image encoder, top level
// Streaming RGBA encoder: commands in, bytes of a QOI file out.
// ----------------------------------------------------------------------------
// A request is taken every cycle while the work queue has room; the front end
// looks the pixel up in the 64-entry color index (one memory read per request;
// the request is registered in the front end, written to the queue and then
// loaded into the output register) and the back end emits one byte per cycle
// from the output register while the result side is popped. A pixel that codes
// to one byte therefore keeps the one-request-per-cycle pace; longer codes
// (LUMA 2 bytes, RGB 4, RGBA 5, plus one pending run byte), a begin (14 bytes)
// and a finish (8 or 9) take longer; the four-deep queue absorbs the
// difference before the input reports full. Begin clears the color index.
// Width and height must be written while the encoder is idle.
// ----------------------------------------------------------------------------
module qoi_image_encoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  qie_pkg::req_type                  req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output qie_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qie_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data
);
   import qie_pkg::*;

   logic [31:0]  width_ff;
   logic [31:0]  height_ff;
   logic         q_push, q_full, q_pop, q_empty;
   desc_type     q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 32'd0;
         height_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data;
            REG_HEIGHT: height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   qie_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_in),
      .q_full   (q_full)
   );

   qie_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   qie_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_data       (q_out),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .image_width  (width_ff),
      .image_height (height_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

endmodule

@@ hw/rtl/qie_checker.sv @@
// ----------------------------------------------------------------------------
// QOI encoder port checker
// Port-level properties of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module qie_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_full,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  qie_pkg::rsp_type   rsp_data
);
   import qie_pkg::*;

   // nothing is left over after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // the rest of a request's bytes follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_byte) |=> !rsp_empty)
      else $error("gap inside the bytes of one request");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind qoi_image_encoder_top qie_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI image encoder testbench
// Sends begin, pixel, finish and unused requests through the input queue and checks
// every byte of the encoded stream against an in-bench QOI encoder model.
// Random idle gaps on both sides; dimensions are changed between batches of images.
// ----------------------------------------------------------------------------
module tb_top;
   import qie_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         SETTLE      = 12;
   localparam int         ITEM_TARGET = 360;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_WIDTH;
   logic [31:0] csr_data = '0;

   qoi_image_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // encoder model state
   logic [31:0] img_width = '0;
   logic [31:0] img_height = '0;
   pix_type     last_pix = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
   pix_type     color_table [INDEX_DEPTH];
   int          run_count = 0;

   req_type pending_requests [$];
   rsp_type qoi_stream_q [$];
   rsp_type want;
   int      errors = 0;
   int      cycle_count = 0;
   int      item_count = 0;
   bit      req_fire = 1'b0;
   bit      gaps_on = 1'b1;
   int      req_idle = 0;
   int      rsp_stall = 0;

   // stimulus generator state
   pix_type gen_last;
   pix_type palette [$];

   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int color_slot(input pix_type p);
      return (int'(p.r) * 3 + int'(p.g) * 5 + int'(p.b) * 7 + int'(p.a) * 11) & 63;
   endfunction

   function automatic void restart_image();
      last_pix = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};
      foreach (color_table[i]) color_table[i] = '0;
      run_count = 0;
   endfunction

   // computes the bytes one request produces and queues them
   function automatic void encode_request(input req_type rq);
      logic [7:0]   code [$];
      logic [111:0] hdr;
      pix_type      px;
      int           h, vr, vg, vb, rg, bg;
      rsp_type      b;
      px = '{r: rq.red, g: rq.green, b: rq.blue, a: rq.alpha};
      case (rq.cmd)
         CMD_BEGIN: begin
            restart_image();
            hdr = {HDR_MAGIC, img_width, img_height, HDR_CHANNELS, HDR_COLORSPACE};
            for (int i = 13; i >= 0; i--) code.push_back(hdr[i*8 +: 8]);
         end
         CMD_PIXEL: begin
            if (px == last_pix) begin
               run_count++;
               if (run_count == int'(RUN_MAX)) begin
                  code.push_back(OP_RUN | 8'(run_count - 1));
                  run_count = 0;
               end
            end else begin
               if (run_count > 0) begin
                  code.push_back(OP_RUN | 8'((run_count - 1) & 63));
                  run_count = 0;
               end
               h = color_slot(px);
               if (color_table[h] == px) begin
                  code.push_back(OP_INDEX | 8'(h));
               end else begin
                  color_table[h] = px;
                  if (px.a == last_pix.a) begin
                     vr = int'(px.r) - int'(last_pix.r);
                     vg = int'(px.g) - int'(last_pix.g);
                     vb = int'(px.b) - int'(last_pix.b);
                     rg = vr - vg;
                     bg = vb - vg;
                     if (vr > -3 && vr < 2 && vg > -3 && vg < 2 && vb > -3 && vb < 2) begin
                        code.push_back(OP_DIFF | 8'(((vr + 2) << 4) | ((vg + 2) << 2) | (vb + 2)));
                     end else if (rg > -9 && rg < 8 && vg > -33 && vg < 32 &&
                                  bg > -9 && bg < 8) begin
                        code.push_back(OP_LUMA | 8'(vg + 32));
                        code.push_back(8'(((rg + 8) << 4) | (bg + 8)));
                     end else begin
                        code.push_back(OP_RGB);
                        code.push_back(px.r);
                        code.push_back(px.g);
                        code.push_back(px.b);
                     end
                  end else begin
                     code.push_back(OP_RGBA);
                     code.push_back(px.r);
                     code.push_back(px.g);
                     code.push_back(px.b);
                     code.push_back(px.a);
                  end
               end
               last_pix = px;
            end
         end
         CMD_FINISH: begin
            if (run_count > 0) begin
               code.push_back(OP_RUN | 8'((run_count - 1) & 63));
               run_count = 0;
            end
            repeat (7) code.push_back(8'h00);
            code.push_back(END_LAST);
         end
         default: ;
      endcase
      foreach (code[k]) begin
         b.out_byte  = code[k];
         b.last_byte = (k == code.size() - 1);
         qoi_stream_q.push_back(b);
      end
   endfunction

   // sample handshakes, predict on accepted requests, check popped bytes
   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_push && !req_full;
         if (req_fire) encode_request(req_data);
         if (rsp_pop && !rsp_empty) begin
            if (qoi_stream_q.size() == 0) begin
               $error("unexpected byte: out_byte %02h last_byte %0b",
                      rsp_data.out_byte, rsp_data.last_byte);
               errors++;
            end else begin
               want = qoi_stream_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.out_byte, rsp_data.out_byte);
                  errors++;
               end
               if (rsp_data.last_byte !== want.last_byte) begin
                  $error("last_byte mismatch: expected %0b, actual %0b",
                         want.last_byte, rsp_data.last_byte);
                  errors++;
               end
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire || !req_push) begin
            if (req_idle > 0) begin
               req_idle--;
               req_push <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_data <= pending_requests.pop_front();
               req_push <= 1'b1;
               req_idle = pick_idle();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // byte consumer with random stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            rsp_stall = pick_idle();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic pix_type make_pix(input int r, input int g, input int b, input int a);
      return '{r: 8'(r), g: 8'(g), b: 8'(b), a: 8'(a)};
   endfunction

   task automatic push_cmd(input logic [1:0] cmd);
      req_type rq;
      rq.cmd   = cmd;
      rq.red   = 8'($urandom);
      rq.green = 8'($urandom);
      rq.blue  = 8'($urandom);
      rq.alpha = 8'($urandom);
      pending_requests.push_back(rq);
      if (cmd != CMD_UNUSED) item_count++;
      if (cmd == CMD_BEGIN) gen_last = make_pix(0, 0, 0, 255);
   endtask

   task automatic push_pixel(input pix_type p);
      pending_requests.push_back('{cmd: CMD_PIXEL, red: p.r, green: p.g, blue: p.b, alpha: p.a});
      item_count++;
      gen_last = p;
      palette.push_back(p);
      if (palette.size() > 16) void'(palette.pop_front());
   endtask

   task automatic repeat_last(input int n);
      repeat (n) push_pixel(gen_last);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_WIDTH) img_width = value;
      else img_height = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_push || qoi_stream_q.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one image worth of mostly well-formed pixel content
   task automatic gen_image(input int steps, input bit do_finish);
      int kind, dg;
      push_cmd(CMD_BEGIN);
      for (int s = 0; s < steps; s++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1: repeat_last(($urandom_range(0, 7) == 0) ? $urandom_range(55, 70)
                                                          : $urandom_range(1, 4));
            2: begin
               if (palette.size() > 0)
                  push_pixel(palette[$urandom_range(0, palette.size() - 1)]);
               else
                  push_pixel(make_pix($urandom, $urandom, $urandom, $urandom));
            end
            3, 4: push_pixel(make_pix(int'(gen_last.r) + int'($urandom_range(0, 3)) - 2,
                                      int'(gen_last.g) + int'($urandom_range(0, 3)) - 2,
                                      int'(gen_last.b) + int'($urandom_range(0, 3)) - 2,
                                      gen_last.a));
            5, 6: begin
               dg = int'($urandom_range(0, 63)) - 32;
               push_pixel(make_pix(int'(gen_last.r) + dg + int'($urandom_range(0, 15)) - 8,
                                   int'(gen_last.g) + dg,
                                   int'(gen_last.b) + dg + int'($urandom_range(0, 15)) - 8,
                                   gen_last.a));
            end
            7: push_pixel(make_pix($urandom, $urandom, $urandom, gen_last.a));
            default: push_pixel(make_pix($urandom, $urandom, $urandom, $urandom));
         endcase
      end
      if (do_finish) push_cmd(CMD_FINISH);
   endtask

   task automatic gen_noise();
      case ($urandom_range(0, 3))
         0: push_cmd(CMD_UNUSED);
         1: push_cmd(CMD_FINISH);
         2: push_pixel(make_pix($urandom, $urandom, $urandom, $urandom));
         default: begin
            // image with a pending run that the next begin cuts off
            push_cmd(CMD_BEGIN);
            push_pixel(make_pix($urandom, $urandom, $urandom, $urandom));
            repeat_last($urandom_range(1, 5));
         end
      endcase
   endtask

   initial begin
      int phase;
      foreach (color_table[i]) color_table[i] = '0;
      gen_last = make_pix(0, 0, 0, 255);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(REG_WIDTH, 32'hffff_ffff);
      write_reg(REG_HEIGHT, 32'h0000_0000);
      @(posedge clock);

      // directed: reset-state pixel, finish and unused command before any begin
      push_pixel(make_pix(0, 0, 0, 255));
      push_cmd(CMD_FINISH);
      push_cmd(CMD_UNUSED);
      push_cmd(CMD_BEGIN);
      push_pixel(make_pix(1, 1, 1, 255));
      repeat_last(2);
      push_pixel(make_pix(25, 30, 28, 255));
      push_pixel(make_pix(255, 0, 128, 255));
      push_pixel(make_pix(255, 255, 255, 0));
      push_pixel(make_pix(1, 1, 1, 255));
      push_pixel(make_pix(0, 0, 0, 0));
      repeat_last(2);
      // restart drops the pending run
      push_cmd(CMD_BEGIN);
      push_pixel(make_pix(0, 0, 0, 0));
      push_pixel(make_pix(255, 255, 255, 255));
      push_pixel(make_pix(0, 0, 0, 255));
      repeat_last(1);
      push_cmd(CMD_FINISH);
      wait_idle();

      phase = 0;
      while (item_count < ITEM_TARGET) begin
         case (phase)
            0: begin
               write_reg(REG_WIDTH, 32'h0000_0000);
               write_reg(REG_HEIGHT, 32'hffff_ffff);
            end
            1: begin
               write_reg(REG_WIDTH, 32'h0000_0000);
               write_reg(REG_HEIGHT, 32'h0000_0000);
            end
            default: begin
               write_reg(REG_WIDTH, $urandom);
               write_reg(REG_HEIGHT, $urandom);
            end
         endcase
         @(posedge clock);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            // runs that hit the flush length exactly and one past it
            push_cmd(CMD_BEGIN);
            push_pixel(make_pix($urandom, $urandom, $urandom, $urandom));
            repeat_last(62);
            push_pixel(make_pix($urandom, $urandom, $urandom, $urandom));
            repeat_last(63);
            push_cmd(CMD_FINISH);
         end
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) == 0) gen_noise();
            gen_image($urandom_range(4, 40), $urandom_range(0, 7) != 0);
         end
         wait_idle();
         phase++;
      end

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/qie_pkg.sv
hw/rtl/qie_front.sv
hw/rtl/qie_queue.sv
hw/rtl/qie_back.sv
hw/rtl/qoi_image_encoder_top.sv
hw/rtl/qie_checker.sv
tb/tb_top.sv
